FILE: rtl/cnv_pkg.sv
package cnv_pkg;

  // Digit count limits
  localparam logic [4:0] LenMin   = 5'd13;
  localparam logic [4:0] LenMax   = 5'd19;
  localparam logic [4:0] CountSat = 5'd20;

  // Character codes
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;

  // Leading digit values used for the brand decode
  localparam logic [3:0] DigThree = 4'd3;
  localparam logic [3:0] DigFour  = 4'd4;
  localparam logic [3:0] DigFive  = 4'd5;
  localparam logic [3:0] DigSix   = 4'd6;
  localparam logic [3:0] DigSeven = 4'd7;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadChar = 2'd1,
    StatusBadLen  = 2'd2,
    StatusBadSum  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BrandAmex   = 3'd0,
    BrandJcb    = 3'd1,
    BrandFour   = 3'd2,
    BrandFive   = 3'd3,
    BrandSix    = 3'd4,
    BrandOther  = 3'd5
  } brand_e;

  typedef struct packed {
    logic [4:0] digit_total;
    brand_e     brand;
    status_e    status;
  } cnv_result_t;

  // Double a digit and fold back into a single digit
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    dbl_digit = (t > 5'd9) ? 4'(t - 5'd9) : t[3:0];
  endfunction

  // Add two digits modulo ten
  function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_mod10 = (s > 5'd9) ? 4'(s - 5'd10) : s[3:0];
  endfunction

  function automatic brand_e brand_of(input logic [3:0] lead, input logic [3:0] second);
    brand_e b;
    b = BrandOther;
    case (lead)
      DigThree: b = (second == DigFour || second == DigSeven) ? BrandAmex : BrandJcb;
      DigFour:  b = BrandFour;
      DigFive:  b = BrandFive;
      DigSix:   b = BrandSix;
      default:  b = BrandOther;
    endcase
    brand_of = b;
  endfunction

endpackage

FILE: rtl/cnv_digit_acc.sv
module cnv_digit_acc import cnv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [7:0]  char_i,
  input  logic        last_i,
  output cnv_result_t res_o
);

  logic [4:0] cnt_q, cnt_d;
  logic [3:0] sum_even_q, sum_even_d;
  logic [3:0] sum_odd_q, sum_odd_d;
  logic [3:0] lead_q, lead_d;
  logic [3:0] second_q, second_d;
  logic       bad_q, bad_d;

  logic       is_space;
  logic       is_digit;
  logic [3:0] dig;
  logic [3:0] dig_dbl;
  logic       even_pos;
  logic [3:0] fin_sum;

  // Classify the character
  assign is_space = (char_i >= CharTab && char_i <= CharCr) || char_i == CharSpace;
  assign is_digit = char_i >= CharZero && char_i <= CharNine;
  assign dig      = 4'(char_i - CharZero);
  assign dig_dbl  = dbl_digit(dig);
  assign even_pos = ~cnt_q[0];

  // Update running sums, count and leading digits
  always_comb begin
    cnt_d      = cnt_q;
    sum_even_d = sum_even_q;
    sum_odd_d  = sum_odd_q;
    lead_d     = lead_q;
    second_d   = second_q;
    bad_d      = bad_q;
    if (!is_space) begin
      if (is_digit) begin
        if (cnt_q == 5'd0) begin
          lead_d = dig;
        end else if (cnt_q == 5'd1) begin
          second_d = dig;
        end
        sum_even_d = add_mod10(sum_even_q, even_pos ? dig_dbl : dig);
        sum_odd_d  = add_mod10(sum_odd_q, even_pos ? dig : dig_dbl);
        if (cnt_q < CountSat) begin
          cnt_d = cnt_q + 5'd1;
        end
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  // Build the result from the updated state
  assign fin_sum = cnt_d[0] ? sum_odd_d : sum_even_d;

  always_comb begin
    res_o.digit_total = cnt_d;
    res_o.brand       = brand_of(lead_d, second_d);
    if (bad_d) begin
      res_o.status = StatusBadChar;
    end else if (cnt_d < LenMin || cnt_d > LenMax) begin
      res_o.status = StatusBadLen;
    end else if (fin_sum != 4'd0) begin
      res_o.status = StatusBadSum;
    end else begin
      res_o.status = StatusOk;
    end
  end

  // Advance state; clear it after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      sum_even_q <= '0;
      sum_odd_q  <= '0;
      lead_q     <= '0;
      second_q   <= '0;
      bad_q      <= 1'b0;
    end else if (en_i) begin
      if (last_i) begin
        cnt_q      <= '0;
        sum_even_q <= '0;
        sum_odd_q  <= '0;
        lead_q     <= '0;
        second_q   <= '0;
        bad_q      <= 1'b0;
      end else begin
        cnt_q      <= cnt_d;
        sum_even_q <= sum_even_d;
        sum_odd_q  <= sum_odd_d;
        lead_q     <= lead_d;
        second_q   <= second_d;
        bad_q      <= bad_d;
      end
    end
  end

endmodule

FILE: rtl/card_number_validator.sv
// Channel   Direction  Contents
// s_axis    in         tdata: char_code[7:0]; tlast: is_last
// m_axis    out        tdata: status[1:0], brand[4:2], digit_total[9:5], zero[15:10]
//
// One character is taken per cycle while s_axis_tready is high. A character is held
// in the input register and updates the running sums as it leaves it; the result of a
// final character passes through the output register before it appears on m_axis.
// Reset clears the input and output valid flags and the running state.
// A final character waits in the input register while an earlier result is
// still held on m_axis; other characters keep flowing.
module card_number_validator import cnv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[1:0], brand[4:2], digit_total[9:5]
);

  logic        in_vld_q;
  logic [7:0]  in_char_q;
  logic        in_last_q;
  logic        out_vld_q;
  cnv_result_t out_res_q;
  cnv_result_t step_res;
  logic        out_free;
  logic        step_en;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step_en       = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_vld_q || step_en;

  // Hold the accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  cnv_digit_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .res_o  (step_res)
  );

  // Load the result register on a final character, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_en && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && in_last_q) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_res_q};

endmodule
